// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared constants, command codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int ITEM_BITS_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_CONTAINS   = 3'd4,
      CMD_FLUSH      = 3'd5
   } cmd_type;

   typedef struct packed {
      logic req_ready;
      logic load_req;
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
      logic flush;
      logic scan_start;
      logic scan_step;
      logic take_data;
      logic res_pass;
      logic res_fail;
      logic load_out;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    full;
      logic    empty;
      logic    match;
      logic    scan_done;
      logic    out_free;
   } sts_type;

endpackage

// File: rtl/bdq_req_if.sv
// ----------------------------------------------------------------------------
// Bounded deque request channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
interface bdq_req_if;
   logic                         valid;
   logic                         ready;
   logic [bdq_pkg::CMD_W-1:0]    command;
   logic [bdq_pkg::VALUE_W-1:0]  item_value;

   modport source (output valid, output command, output item_value, input ready);
   modport sink   (input valid, input command, input item_value, output ready);
endinterface

// File: rtl/bdq_rsp_if.sv
// ----------------------------------------------------------------------------
// Bounded deque response channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [bdq_pkg::VALUE_W-1:0]  item_out;
   logic [bdq_pkg::COUNT_W-1:0]  count_out;
   logic                         empty_out;

   modport source (output valid, output ok, output item_out, output count_out,
                   output empty_out, input ready);
   modport sink   (input valid, input ok, input item_out, input count_out,
                   input empty_out, output ready);
endinterface

// File: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded deque controller
// Sequences each command through execute, read, scan and result hand-off.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  bdq_pkg::sts_type sts,
   output bdq_pkg::ctl_type ctl
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_READ = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            ctl.req_ready = 1'b1;
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (sts.cmd)
               bdq_pkg::CMD_PUSH_FRONT: begin
                  ctl.push_front = !sts.full;
                  ctl.res_fail   = sts.full;
               end
               bdq_pkg::CMD_PUSH_BACK: begin
                  ctl.push_back = !sts.full;
                  ctl.res_fail  = sts.full;
               end
               bdq_pkg::CMD_POP_FRONT: begin
                  if (sts.empty) begin
                     ctl.res_fail = 1'b1;
                  end else begin
                     ctl.pop_front = 1'b1;
                     state_in      = ST_READ;
                  end
               end
               bdq_pkg::CMD_POP_BACK: begin
                  if (sts.empty) begin
                     ctl.res_fail = 1'b1;
                  end else begin
                     ctl.pop_back = 1'b1;
                     state_in     = ST_READ;
                  end
               end
               bdq_pkg::CMD_CONTAINS: begin
                  if (sts.empty) begin
                     ctl.res_fail = 1'b1;
                  end else begin
                     ctl.scan_start = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end
               bdq_pkg::CMD_FLUSH: begin
                  ctl.flush = 1'b1;
               end
               default: begin
                  ctl.res_fail = 1'b1;
               end
            endcase
         end
         ST_READ: begin
            ctl.take_data = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SCAN: begin
            if (sts.match) begin
               ctl.res_pass = 1'b1;
               state_in     = ST_DONE;
            end else if (sts.scan_done) begin
               ctl.res_fail = 1'b1;
               state_in     = ST_DONE;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               ctl.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/bdq_datapath.sv
// ----------------------------------------------------------------------------
// Bounded deque datapath
// Ring pointers, item store, search compare and the result register.
// ----------------------------------------------------------------------------
module bdq_datapath #(
   parameter int CAPACITY  = bdq_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = bdq_pkg::ITEM_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bdq_pkg::ctl_type             ctl,
   output bdq_pkg::sts_type             sts,
   input  logic [bdq_pkg::CMD_W-1:0]    req_command,
   input  logic [bdq_pkg::VALUE_W-1:0]  req_item_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_ok,
   output logic [bdq_pkg::VALUE_W-1:0]  rsp_item_out,
   output logic [bdq_pkg::COUNT_W-1:0]  rsp_count_out,
   output logic                         rsp_empty_out
);

   localparam int PTR_W   = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int STORE_W = (ITEM_BITS < bdq_pkg::VALUE_W) ? ITEM_BITS : bdq_pkg::VALUE_W;
   localparam logic [PTR_W:0]   CAP_WIDE = (PTR_W + 1)'(CAPACITY);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

   logic [bdq_pkg::CMD_W-1:0] cmd_ff;
   logic [STORE_W-1:0]        val_ff;
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic                      res_ok_ff, res_ok_in;
   logic [bdq_pkg::VALUE_W-1:0] res_item_ff, res_item_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_ok_ff;
   logic [bdq_pkg::VALUE_W-1:0] out_item_ff;
   logic [bdq_pkg::COUNT_W-1:0] out_count_ff;
   logic                      out_empty_ff;

   logic                      wr_en, rd_en;
   logic [PTR_W-1:0]          wr_addr, rd_addr;
   logic [STORE_W-1:0]        rd_data;
   logic [PTR_W-1:0]          head_dec, head_inc;
   logic [PTR_W-1:0]          back_addr, tail_addr, scan_addr;
   logic [CNT_W-1:0]          count_dec;
   logic [bdq_pkg::VALUE_W+STORE_W-1:0]       data_wide;
   logic [bdq_pkg::COUNT_W+CNT_W-1:0]         count_wide;

   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off[PTR_W-1:0]};
      if (sum >= CAP_WIDE) begin
         sum = sum - CAP_WIDE;
      end
      return sum[PTR_W-1:0];
   endfunction

   assign head_dec   = (head_ff == '0) ? PTR_LAST : head_ff - PTR_W'(1);
   assign head_inc   = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
   assign count_dec  = count_ff - CNT_W'(1);
   assign tail_addr  = ring_add(head_ff, count_ff);
   assign back_addr  = ring_add(head_ff, count_dec);
   assign scan_addr  = ring_add(head_ff, scan_ff);
   assign data_wide  = {{bdq_pkg::VALUE_W{1'b0}}, rd_data};
   assign count_wide = {{bdq_pkg::COUNT_W{1'b0}}, count_ff};

   assign wr_en   = ctl.push_front || ctl.push_back;
   assign wr_addr = ctl.push_front ? head_dec : tail_addr;
   assign rd_en   = ctl.pop_front || ctl.pop_back || ctl.scan_start || ctl.scan_step;

   always_comb begin
      rd_addr = head_ff;
      if (ctl.pop_back) begin
         rd_addr = back_addr;
      end else if (ctl.scan_step) begin
         rd_addr = scan_addr;
      end
   end

   bdq_ram #(
      .WIDTH(STORE_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(val_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      res_ok_in   = res_ok_ff;
      res_item_in = res_item_ff;
      if (ctl.push_front) begin
         head_in = head_dec;
      end
      if (ctl.pop_front) begin
         head_in = head_inc;
      end
      if (ctl.push_front || ctl.push_back) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctl.pop_front || ctl.pop_back) begin
         count_in = count_dec;
      end
      if (ctl.flush) begin
         head_in  = '0;
         count_in = '0;
      end
      if (ctl.scan_start) begin
         scan_in = CNT_W'(1);
      end
      if (ctl.scan_step) begin
         scan_in = scan_ff + CNT_W'(1);
      end
      if (ctl.push_front || ctl.push_back || ctl.pop_front || ctl.pop_back ||
          ctl.res_pass) begin
         res_ok_in   = 1'b1;
         res_item_in = '0;
      end
      if (ctl.res_fail || ctl.flush) begin
         res_ok_in   = 1'b0;
         res_item_in = '0;
      end
      if (ctl.take_data) begin
         res_item_in = data_wide[bdq_pkg::VALUE_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff <= req_command;
         val_ff <= req_item_value[STORE_W-1:0];
      end
      scan_ff     <= scan_in;
      res_ok_ff   <= res_ok_in;
      res_item_ff <= res_item_in;
      if (ctl.load_out) begin
         out_ok_ff    <= res_ok_ff;
         out_item_ff  <= res_item_ff;
         out_count_ff <= count_wide[bdq_pkg::COUNT_W-1:0];
         out_empty_ff <= (count_ff == '0);
      end
   end

   assign sts.cmd       = bdq_pkg::cmd_type'(cmd_ff);
   assign sts.full      = (count_ff == CNT_FULL);
   assign sts.empty     = (count_ff == '0);
   assign sts.match     = (rd_data == val_ff);
   assign sts.scan_done = (scan_ff == count_ff);
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_ok        = out_ok_ff;
   assign rsp_item_out  = out_item_ff;
   assign rsp_count_out = out_count_ff;
   assign rsp_empty_out = out_empty_ff;

endmodule

// File: rtl/bounded_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// Bounded deque with search
// Double-ended queue in a ring store with push, pop, search and flush.
//
//   Channel   Direction  Word
//   req_bus   in         command, item_value
//   rsp_bus   out        ok, item_out, count_out, empty_out
//
// A push, a flush or a refused command passes through the execute state and then
// the done state, which loads its result into the output register; a pop also
// passes through a read state, for one store read with registered data.
// A search reads one stored entry per cycle in the scan state.
// One command is in progress at a time; a new word is accepted while the
// previous result waits in the output register, and a result that is not
// taken holds the next one in the done state.
// Reset clears the pointers and the count; the store itself is not cleared.
// ----------------------------------------------------------------------------
module bounded_deque_with_search_unit #(
   parameter int CAPACITY  = bdq_pkg::CAPACITY_DEF,
   parameter int ITEM_BITS = bdq_pkg::ITEM_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   bdq_req_if.sink    req_bus,
   bdq_rsp_if.source  rsp_bus
);

   bdq_pkg::ctl_type ctl;
   bdq_pkg::sts_type sts;

   bdq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .sts      (sts),
      .ctl      (ctl)
   );

   bdq_datapath #(
      .CAPACITY (CAPACITY),
      .ITEM_BITS(ITEM_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .req_command   (req_bus.command),
      .req_item_value(req_bus.item_value),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_ok        (rsp_bus.ok),
      .rsp_item_out  (rsp_bus.item_out),
      .rsp_count_out (rsp_bus.count_out),
      .rsp_empty_out (rsp_bus.empty_out)
   );

   assign req_bus.ready = ctl.req_ready && !reset;

`ifndef SYNTHESIS
   a_one_update: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.push_front, ctl.push_back, ctl.pop_front, ctl.pop_back,
                ctl.flush, ctl.scan_start, ctl.scan_step}))
      else $error("More than one store update in a cycle.");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      (ctl.pop_front || ctl.pop_back) |=> ctl.take_data)
      else $error("Pop read data was not captured.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      ctl.load_req |=> !ctl.req_ready)
      else $error("A word was accepted while a command was in progress.");

   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("A result overwrote one not yet taken.");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Bounded deque with search testbench
// Sends command words through the request channel and checks every result word
// against a behavioral deque kept in the testbench. Directed tests cover the
// empty and full edges, refused pushes, failed pops, search, flush and the
// unused command codes. Constrained-free random traffic then swings the store
// between empty and full, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH       = bdq_pkg::CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = bdq_pkg::CAPACITY_DEF + 10;

   localparam logic [bdq_pkg::CMD_W-1:0] CMD_RESERVED_LO = 3'd6;
   localparam logic [bdq_pkg::CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

   typedef struct packed {
      logic                        ok;
      logic [bdq_pkg::VALUE_W-1:0] item;
      logic [bdq_pkg::COUNT_W-1:0] count;
      logic                        empty;
   } outcome_type;

   logic clock;
   logic reset;

   bdq_req_if req_bus ();
   bdq_rsp_if rsp_bus ();

   bounded_deque_with_search_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [bdq_pkg::VALUE_W-1:0] ring_model [DEPTH];
   int                          front_idx;
   int                          held;
   outcome_type                 pending_outcomes [$];
   int                          error_count;
   int                          cycle_count;
   int                          stall_left;
   bit                          pacing_on;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Most gaps are zero or short; a few are long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!pacing_on || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic outcome_type apply_command(
         input logic [bdq_pkg::CMD_W-1:0]   cmd,
         input logic [bdq_pkg::VALUE_W-1:0] value);
      outcome_type res;
      int          pos;
      res = '0;
      case (cmd)
         bdq_pkg::CMD_PUSH_FRONT: begin
            if (held < DEPTH) begin
               front_idx = (front_idx + DEPTH - 1) % DEPTH;
               ring_model[front_idx] = value;
               held++;
               res.ok = 1'b1;
            end
         end
         bdq_pkg::CMD_PUSH_BACK: begin
            if (held < DEPTH) begin
               ring_model[(front_idx + held) % DEPTH] = value;
               held++;
               res.ok = 1'b1;
            end
         end
         bdq_pkg::CMD_POP_FRONT: begin
            if (held != 0) begin
               res.item = ring_model[front_idx];
               front_idx = (front_idx + 1) % DEPTH;
               held--;
               res.ok = 1'b1;
            end
         end
         bdq_pkg::CMD_POP_BACK: begin
            if (held != 0) begin
               res.item = ring_model[(front_idx + held - 1) % DEPTH];
               held--;
               res.ok = 1'b1;
            end
         end
         bdq_pkg::CMD_CONTAINS: begin
            for (pos = 0; pos < held; pos++)
               if (ring_model[(front_idx + pos) % DEPTH] == value) res.ok = 1'b1;
         end
         bdq_pkg::CMD_FLUSH: begin
            held = 0;
            front_idx = 0;
         end
         default: ;
      endcase
      res.count = bdq_pkg::COUNT_W'(held);
      res.empty = (held == 0);
      return res;
   endfunction

   task automatic issue_command(input logic [bdq_pkg::CMD_W-1:0]   cmd,
                                input logic [bdq_pkg::VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.command    = cmd;
      req_bus.item_value = value;
      do @(posedge clock); while (!req_bus.ready);
      pending_outcomes.push_back(apply_command(cmd, value));
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type observed;
      outcome_type wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         observed = {rsp_bus.ok, rsp_bus.item_out, rsp_bus.count_out, rsp_bus.empty_out};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result word with none expected, actual ok=%0b item=%h count=%0d empty=%0b",
                     $time, observed.ok, observed.item, observed.count, observed.empty);
            error_count++;
         end else begin
            wanted = pending_outcomes.pop_front();
            if (observed !== wanted) begin
               $display("%0t: mismatch, expected ok=%0b item=%h count=%0d empty=%0b",
                        $time, wanted.ok, wanted.item, wanted.count, wanted.empty);
               $display("%0t:           actual ok=%0b item=%h count=%0d empty=%0b",
                        $time, observed.ok, observed.item, observed.count, observed.empty);
               error_count++;
            end
         end
      end
   end

   function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return bdq_pkg::VALUE_W'($urandom_range(0, 7));
      if (r < 45) return '0;
      if (r < 50) return '1;
      return $urandom;
   endfunction

   function automatic logic [bdq_pkg::VALUE_W-1:0] pick_search_value();
      if (held > 0 && $urandom_range(0, 99) < 60)
         return ring_model[(front_idx + $urandom_range(0, held - 1)) % DEPTH];
      return pick_value();
   endfunction

   task automatic test_empty_store();
      issue_command(bdq_pkg::CMD_POP_FRONT, '1);
      issue_command(bdq_pkg::CMD_POP_BACK, '0);
      issue_command(bdq_pkg::CMD_CONTAINS, '0);
      issue_command(bdq_pkg::CMD_FLUSH, 32'h5A5A_A5A5);
      issue_command(CMD_RESERVED_LO, 32'h1234_5678);
      issue_command(CMD_RESERVED_HI, '1);
   endtask

   task automatic test_full_store();
      int i;
      issue_command(bdq_pkg::CMD_PUSH_BACK, '0);
      issue_command(bdq_pkg::CMD_PUSH_FRONT, '1);
      for (i = 2; i < DEPTH; i++)
         issue_command(i % 2 ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK, $urandom);
      issue_command(bdq_pkg::CMD_PUSH_FRONT, 32'hDEAD_BEEF);
      issue_command(bdq_pkg::CMD_PUSH_BACK, 32'hDEAD_BEEF);
      issue_command(bdq_pkg::CMD_CONTAINS, '1);
      issue_command(bdq_pkg::CMD_CONTAINS, 32'hDEAD_BEEF);
      issue_command(bdq_pkg::CMD_POP_FRONT, '0);
      issue_command(bdq_pkg::CMD_POP_BACK, '0);
      issue_command(bdq_pkg::CMD_FLUSH, '0);
      issue_command(bdq_pkg::CMD_POP_FRONT, '0);
   endtask

   task automatic test_random_traffic(input int num_items);
      int                          i;
      int                          r;
      bit                          filling;
      logic [bdq_pkg::CMD_W-1:0]   cmd;
      logic [bdq_pkg::VALUE_W-1:0] value;
      filling = 1'b1;
      for (i = 0; i < num_items; i++) begin
         if (i % 150 == 0) pacing_on = ($urandom_range(0, 3) != 0);
         if (held == DEPTH) filling = 1'b0;
         else if (held == 0) filling = 1'b1;
         else if ($urandom_range(0, 99) < 3) filling = ~filling;
         r = $urandom_range(0, 99);
         if (r < 35) cmd = filling ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_POP_FRONT;
         else if (r < 70) cmd = filling ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_POP_BACK;
         else if (r < 78) cmd = filling ? bdq_pkg::CMD_POP_FRONT : bdq_pkg::CMD_PUSH_FRONT;
         else if (r < 86) cmd = filling ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_PUSH_BACK;
         else if (r < 97) cmd = bdq_pkg::CMD_CONTAINS;
         else if (r < 98) cmd = bdq_pkg::CMD_FLUSH;
         else cmd = r[0] ? CMD_RESERVED_HI : CMD_RESERVED_LO;
         value = (cmd == bdq_pkg::CMD_CONTAINS) ? pick_search_value() : pick_value();
         issue_command(cmd, value);
      end
      pacing_on = 1'b1;
   endtask

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = bdq_pkg::CMD_PUSH_FRONT;
      req_bus.item_value = '0;
      front_idx          = 0;
      held               = 0;
      error_count        = 0;
      cycle_count        = 0;
      pacing_on          = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_store();
      test_full_store();
      test_random_traffic(1300);

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
